### hw/rtl/i2cseq_pkg.sv
`default_nettype none
package i2cseq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 8;

	localparam int unsigned TAG_W   = 8;
	localparam int unsigned CMD_W   = 4;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned ENTRY_W = 10;

	localparam logic [2:0] KIND_WRITE     = 3'd0;
	localparam logic [2:0] KIND_READ      = 3'd1;
	localparam logic [2:0] KIND_XFER_OK   = 3'd2;
	localparam logic [2:0] KIND_XFER_ERR  = 3'd3;
	localparam logic [2:0] KIND_SDA       = 3'd4;
	localparam logic [2:0] KIND_FORCE_REC = 3'd5;

	localparam logic [CMD_W-1:0] CMD_START_WRITE = 4'd0;
	localparam logic [CMD_W-1:0] CMD_START_READ  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_DONE_OK     = 4'd2;
	localparam logic [CMD_W-1:0] CMD_DONE_ERR    = 4'd3;
	localparam logic [CMD_W-1:0] CMD_DROPPED     = 4'd4;
	localparam logic [CMD_W-1:0] CMD_REC_BEGIN   = 4'd5;
	localparam logic [CMD_W-1:0] CMD_TOGGLE_SCL  = 4'd6;
	localparam logic [CMD_W-1:0] CMD_REC_END     = 4'd7;
	localparam logic [CMD_W-1:0] CMD_LOSS_REPORT = 4'd8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		OP_WRITE_REQ,
		OP_READ_REQ,
		OP_XFER_OK,
		OP_XFER_ERR,
		OP_SDA,
		OP_FORCE_REC
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [TAG_W-1:0] tag;
		logic             notice;
		logic             busy;
		logic             sda;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} front_out_t;

endpackage
`default_nettype wire

### hw/rtl/i2cseq_ram.sv
`default_nettype none
module i2cseq_ram #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### hw/rtl/i2cseq_front.sv
`default_nettype none
module i2cseq_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [2:0]               kind,
	input  wire logic [7:0]               request_tag,
	input  wire logic                     wants_notice,
	input  wire logic                     bus_busy,
	input  wire logic                     sda_level,
	output i2cseq_pkg::front_out_t        fo,
	input  wire logic                     pop
);

	i2cseq_pkg::item_t dec_item;
	logic              keep;
	logic              push;

	i2cseq_pkg::item_t fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;

	always_comb begin
		dec_item.op     = i2cseq_pkg::OP_WRITE_REQ;
		dec_item.tag    = request_tag;
		dec_item.notice = wants_notice;
		dec_item.busy   = bus_busy;
		dec_item.sda    = sda_level;
		keep            = 1'b1;
		unique case (kind)
			i2cseq_pkg::KIND_WRITE:     dec_item.op = i2cseq_pkg::OP_WRITE_REQ;
			i2cseq_pkg::KIND_READ:      dec_item.op = i2cseq_pkg::OP_READ_REQ;
			i2cseq_pkg::KIND_XFER_OK:   dec_item.op = i2cseq_pkg::OP_XFER_OK;
			i2cseq_pkg::KIND_XFER_ERR:  dec_item.op = i2cseq_pkg::OP_XFER_ERR;
			i2cseq_pkg::KIND_SDA:       dec_item.op = i2cseq_pkg::OP_SDA;
			i2cseq_pkg::KIND_FORCE_REC: dec_item.op = i2cseq_pkg::OP_FORCE_REC;
			// undefined kinds have no effect: accept and drop
			default:                    keep = 1'b0;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= dec_item;
		end
	end

	assign fo.valid = (fill_q != 2'd0);
	assign fo.item  = fifo_q[rd_ptr_q];

endmodule
`default_nettype wire

### hw/rtl/i2cseq_back.sv
`default_nettype none
module i2cseq_back #(
	parameter int unsigned QUEUE_DEPTH = i2cseq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire i2cseq_pkg::front_out_t fi,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [3:0]                  command,
	output logic [7:0]                  out_tag,
	output logic                        notify_requester,
	output logic [15:0]                 report_count,
	output logic                        last
);

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	typedef enum logic [1:0] {PH_IDLE, PH_WRITE, PH_READ, PH_RECOV} phase_t;
	typedef enum logic [2:0] {
		ST_ITEM,
		ST_IDLE_ENTRY,
		ST_REC_BEGIN,
		ST_REC_TOGGLE,
		ST_START_Q
	} step_t;

	step_t                               step_q, step_d;
	phase_t                              phase_q, phase_d;
	logic                                rdp_q, rdp_d;
	logic [i2cseq_pkg::TAG_W-1:0]        cur_tag_q, cur_tag_d;
	logic                                cur_notice_q, cur_notice_d;
	logic [PTR_W-1:0]                    wp_q, wp_d, rp_q, rp_d;
	logic [i2cseq_pkg::COUNT_W-1:0]      lost_q, lost_d, retry_q, retry_d;
	logic                                busy_q, busy_d;

	logic                                out_valid_q, out_valid_d;
	logic [i2cseq_pkg::CMD_W-1:0]        cmd_q, cmd_d;
	logic [i2cseq_pkg::TAG_W-1:0]        tag_q, tag_d;
	logic                                note_q, note_d;
	logic [i2cseq_pkg::COUNT_W-1:0]      cnt_q, cnt_d;
	logic                                last_q, last_d;

	logic                                slot_free;
	logic [PTR_W-1:0]                    wp_next, rp_next;
	logic                                q_empty, q_full;
	logic [i2cseq_pkg::COUNT_W-1:0]      lost_inc, retry_inc;
	logic                                idle_more;

	logic                                ram_we;
	logic [i2cseq_pkg::ENTRY_W-1:0]      ram_wdata, ram_rdata;

	assign slot_free = !out_valid_q || out_ready;
	assign wp_next   = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
	assign rp_next   = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
	assign q_empty   = (wp_q == rp_q);
	assign q_full    = (wp_next == rp_q);
	assign lost_inc  = (lost_q == i2cseq_pkg::COUNT_MAX) ? lost_q : lost_q + 1'b1;
	assign retry_inc = (retry_q == i2cseq_pkg::COUNT_MAX) ? retry_q : retry_q + 1'b1;
	// idle entry of this transaction adds results after the first one
	assign idle_more = (lost_q != '0) || fi.item.busy || !q_empty;

	assign ram_wdata = {fi.item.op == i2cseq_pkg::OP_READ_REQ,
		(fi.item.op == i2cseq_pkg::OP_READ_REQ) && fi.item.notice, fi.item.tag};

	i2cseq_ram #(
		.WIDTH (i2cseq_pkg::ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_pending (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		logic                           emit;
		logic [i2cseq_pkg::CMD_W-1:0]   e_cmd;
		logic [i2cseq_pkg::TAG_W-1:0]   e_tag;
		logic                           e_note;
		logic [i2cseq_pkg::COUNT_W-1:0] e_cnt;
		logic                           e_last;
		logic                           go_idle;
		logic                           is_read;

		emit    = 1'b0;
		e_cmd   = i2cseq_pkg::CMD_START_WRITE;
		e_tag   = '0;
		e_note  = 1'b0;
		e_cnt   = '0;
		e_last  = 1'b1;
		go_idle = 1'b0;
		is_read = (fi.item.op == i2cseq_pkg::OP_READ_REQ);

		step_d       = step_q;
		phase_d      = phase_q;
		rdp_d        = rdp_q;
		cur_tag_d    = cur_tag_q;
		cur_notice_d = cur_notice_q;
		wp_d         = wp_q;
		rp_d         = rp_q;
		lost_d       = lost_q;
		retry_d      = retry_q;
		busy_d       = busy_q;
		pop          = 1'b0;
		ram_we       = 1'b0;

		unique case (step_q)
			ST_ITEM: begin
				if (fi.valid && slot_free) begin
					pop = 1'b1;
					unique case (fi.item.op)
						i2cseq_pkg::OP_WRITE_REQ, i2cseq_pkg::OP_READ_REQ: begin
							if (phase_q == PH_IDLE) begin
								cur_tag_d    = fi.item.tag;
								cur_notice_d = is_read && fi.item.notice;
								rdp_d        = 1'b0;
								phase_d      = is_read ? PH_READ : PH_WRITE;
								emit         = 1'b1;
								e_cmd        = i2cseq_pkg::CMD_START_WRITE;
								e_tag        = fi.item.tag;
							end else if (!q_full) begin
								ram_we = 1'b1;
								wp_d   = wp_next;
							end else begin
								lost_d = lost_inc;
								emit   = 1'b1;
								e_cmd  = i2cseq_pkg::CMD_DROPPED;
								e_tag  = fi.item.tag;
								e_cnt  = lost_inc;
							end
						end
						i2cseq_pkg::OP_XFER_OK: begin
							if (phase_q == PH_WRITE) begin
								emit    = 1'b1;
								e_cmd   = i2cseq_pkg::CMD_DONE_OK;
								e_tag   = cur_tag_q;
								e_last  = !idle_more;
								go_idle = 1'b1;
							end else if (phase_q == PH_READ) begin
								if (!rdp_q) begin
									// address phase done: start the data phase
									rdp_d = 1'b1;
									emit  = 1'b1;
									e_cmd = i2cseq_pkg::CMD_START_READ;
									e_tag = cur_tag_q;
								end else begin
									emit    = 1'b1;
									e_cmd   = i2cseq_pkg::CMD_DONE_OK;
									e_tag   = cur_tag_q;
									e_note  = cur_notice_q;
									e_last  = !idle_more;
									go_idle = 1'b1;
								end
							end
						end
						i2cseq_pkg::OP_XFER_ERR: begin
							if (phase_q == PH_WRITE || phase_q == PH_READ) begin
								emit    = 1'b1;
								e_cmd   = i2cseq_pkg::CMD_DONE_ERR;
								e_tag   = cur_tag_q;
								e_last  = !idle_more;
								go_idle = 1'b1;
							end else if (phase_q == PH_IDLE) begin
								go_idle = 1'b1;
							end
						end
						i2cseq_pkg::OP_SDA: begin
							if (phase_q == PH_RECOV) begin
								emit = 1'b1;
								if (fi.item.sda) begin
									e_cmd   = i2cseq_pkg::CMD_REC_END;
									e_cnt   = retry_inc;
									e_last  = !idle_more;
									retry_d = '0;
									go_idle = 1'b1;
								end else begin
									e_cmd   = i2cseq_pkg::CMD_TOGGLE_SCL;
									retry_d = retry_inc;
								end
							end
						end
						i2cseq_pkg::OP_FORCE_REC: begin
							if (phase_q == PH_IDLE) begin
								step_d = ST_REC_BEGIN;
							end
						end
					endcase
					if (go_idle) begin
						phase_d = PH_IDLE;
						busy_d  = fi.item.busy;
						step_d  = ST_IDLE_ENTRY;
					end
				end
			end
			ST_IDLE_ENTRY: begin
				// the queue head is read during this step for a possible start
				if (slot_free) begin
					if (lost_q != '0) begin
						emit   = 1'b1;
						e_cmd  = i2cseq_pkg::CMD_LOSS_REPORT;
						e_cnt  = lost_q;
						e_last = !(busy_q || !q_empty);
						lost_d = '0;
					end
					if (busy_q) begin
						step_d = ST_REC_BEGIN;
					end else if (!q_empty) begin
						step_d = ST_START_Q;
					end else begin
						step_d = ST_ITEM;
					end
				end
			end
			ST_REC_BEGIN: begin
				if (slot_free) begin
					phase_d = PH_RECOV;
					emit    = 1'b1;
					e_cmd   = i2cseq_pkg::CMD_REC_BEGIN;
					e_last  = 1'b0;
					step_d  = ST_REC_TOGGLE;
				end
			end
			ST_REC_TOGGLE: begin
				if (slot_free) begin
					emit   = 1'b1;
					e_cmd  = i2cseq_pkg::CMD_TOGGLE_SCL;
					step_d = ST_ITEM;
				end
			end
			ST_START_Q: begin
				if (slot_free) begin
					cur_tag_d    = ram_rdata[7:0];
					cur_notice_d = ram_rdata[8];
					rdp_d        = 1'b0;
					phase_d      = ram_rdata[9] ? PH_READ : PH_WRITE;
					rp_d         = rp_next;
					emit         = 1'b1;
					e_cmd        = i2cseq_pkg::CMD_START_WRITE;
					e_tag        = ram_rdata[7:0];
					step_d       = ST_ITEM;
				end
			end
			default: step_d = ST_ITEM;
		endcase

		out_valid_d = out_valid_q;
		cmd_d       = cmd_q;
		tag_d       = tag_q;
		note_d      = note_q;
		cnt_d       = cnt_q;
		last_d      = last_q;
		if (emit) begin
			out_valid_d = 1'b1;
			cmd_d       = e_cmd;
			tag_d       = e_tag;
			note_d      = e_note;
			cnt_d       = e_cnt;
			last_d      = e_last;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_ITEM;
			phase_q      <= PH_IDLE;
			rdp_q        <= 1'b0;
			cur_tag_q    <= '0;
			cur_notice_q <= 1'b0;
			wp_q         <= '0;
			rp_q         <= '0;
			lost_q       <= '0;
			retry_q      <= '0;
			busy_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			cmd_q        <= i2cseq_pkg::CMD_START_WRITE;
			tag_q        <= '0;
			note_q       <= 1'b0;
			cnt_q        <= '0;
			last_q       <= 1'b0;
		end else begin
			step_q       <= step_d;
			phase_q      <= phase_d;
			rdp_q        <= rdp_d;
			cur_tag_q    <= cur_tag_d;
			cur_notice_q <= cur_notice_d;
			wp_q         <= wp_d;
			rp_q         <= rp_d;
			lost_q       <= lost_d;
			retry_q      <= retry_d;
			busy_q       <= busy_d;
			out_valid_q  <= out_valid_d;
			cmd_q        <= cmd_d;
			tag_q        <= tag_d;
			note_q       <= note_d;
			cnt_q        <= cnt_d;
			last_q       <= last_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign command          = cmd_q;
	assign out_tag          = tag_q;
	assign notify_requester = note_q;
	assign report_count     = cnt_q;
	assign last             = last_q;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (wp_q != rp_q))
		else $error("pending queue write pointer caught up with read pointer");

	a_notify_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && note_q) |-> (cmd_q == i2cseq_pkg::CMD_DONE_OK))
		else $error("requester notice on a command other than done ok");

	a_start_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_START_Q) |-> (wp_q != rp_q))
		else $error("queued start with empty pending queue");

	a_loss_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_IDLE_ENTRY && slot_free) |=> (lost_q == '0))
		else $error("loss count not cleared on idle entry");

	a_pop_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != ST_ITEM) |-> !pop)
		else $error("transaction taken while idle entry sequence runs");

endmodule
`default_nettype wire

### hw/rtl/i2c_transaction_sequencer.sv
// A transaction passes the two-entry front FIFO; its first command is then registered at the output.
// Throughput: one transaction per cycle when it yields a single command and the output is not
// stalled. Entering idle adds the idle-entry step, which also carries any loss report; a
// recovery start adds the begin and toggle steps, a queued start the queued-start step; stalls hold each.
// Reset: arst_n clears phase, pointers, counters and the output; queue contents stay.
`default_nettype none
module i2c_transaction_sequencer #(
	parameter int unsigned QUEUE_DEPTH = i2cseq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  kind,
	input  wire logic [7:0]  request_tag,
	input  wire logic        wants_notice,
	input  wire logic        bus_busy,
	input  wire logic        sda_level,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       command,
	output logic [7:0]       out_tag,
	output logic             notify_requester,
	output logic [15:0]      report_count,
	output logic             last
);

	i2cseq_pkg::front_out_t front_out;
	logic                   pop;

	i2cseq_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.request_tag  (request_tag),
		.wants_notice (wants_notice),
		.bus_busy     (bus_busy),
		.sda_level    (sda_level),
		.fo           (front_out),
		.pop          (pop)
	);

	i2cseq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.fi               (front_out),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.command          (command),
		.out_tag          (out_tag),
		.notify_requester (notify_requester),
		.report_count     (report_count),
		.last             (last)
	);

endmodule
`default_nettype wire
